// File: rtl/attribute_closure_engine_macros.svh
// Assertion macros shared by the attribute closure engine RTL.
`ifndef ATTRIBUTE_CLOSURE_ENGINE_MACROS_SVH
`define ATTRIBUTE_CLOSURE_ENGINE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ACE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ACE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ace_pkg.sv
// Shared types and constants of the attribute closure engine.
package ace_pkg;

    localparam int FIELD_W    = 64;
    localparam int KIND_W     = 2;
    localparam int COUNT_W    = 7;
    localparam int IN_DATA_W  = 2 * FIELD_W;             // left_set, right_set
    localparam int OUT_DATA_W = 72;                      // closure_set, rule_count, pad

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

// File: rtl/ace_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ace_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/attribute_closure_engine.sv
// Top level of the attribute closure engine: rule table, insert search, closure passes.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tuser: kind; tdata: left_set, right_set
//  m_*     | out | m_tvalid/m_tready  | tuser: status; tdata: closure_set, rule_count
//
// One request at a time. The rule table is one RAM (left and right masks side by
// side), read one entry per cycle with registered read data.
// Insert: one linear search, with the write-back at its end.
// Query: passes over the table repeat until one adds nothing, so at most
// ATTR_BITS + 1 passes. Clear and unused kinds skip the scan.
// Reset empties the table at once (count only). A stalled output holds the result;
// the next request is taken as soon as the result sits in the output register.
`include "attribute_closure_engine_macros.svh"

module attribute_closure_engine #(
    parameter int TABLE_DEPTH = 64,
    parameter int ATTR_BITS   = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ace_pkg::IN_DATA_W-1:0]   s_tdata,   // [63:0] left_set, [127:64] right_set
    input  logic [ace_pkg::KIND_W-1:0]      s_tuser,   // [1:0] kind
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ace_pkg::OUT_DATA_W-1:0]  m_tdata,   // [63:0] closure_set, [70:64] rule_count
    output logic [0:0]                      m_tuser    // [0] status
);

    import ace_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    state_t                 state_reg, state_next;
    logic [KIND_W-1:0]      kind_reg, kind_next;
    logic [ATTR_BITS-1:0]   left_reg, left_next;
    logic [ATTR_BITS-1:0]   right_reg, right_next;
    logic [ATTR_BITS-1:0]   set_reg, set_next;
    logic                   status_reg, status_next;
    logic                   changed_reg, changed_next;
    logic [CW-1:0]          used_reg, used_next;
    logic [CW-1:0]          issue_idx_reg, issue_idx_next;
    logic                   rd_valid_reg, rd_valid_next;
    logic                   rd_last_reg, rd_last_next;
    logic [AW-1:0]          rd_addr_reg, rd_addr_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [ATTR_BITS-1:0]   m_set_reg, m_set_next;
    logic [COUNT_W-1:0]     m_count_reg, m_count_next;
    logic                   m_status_reg, m_status_next;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [2*ATTR_BITS-1:0] ram_wdata;
    logic [2*ATTR_BITS-1:0] ram_rdata;
    logic [ATTR_BITS-1:0]   ram_left;
    logic [ATTR_BITS-1:0]   ram_right;

    logic                   accept;
    logic                   out_free;
    logic                   issue;
    logic                   table_empty;
    logic                   match;
    logic                   applies;
    logic                   grows;
    logic                   pass_end;
    logic                   scan_done;

    ace_ram #(
        .WIDTH (2 * ATTR_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_rules (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (issue_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign ram_left  = ram_rdata[ATTR_BITS-1:0];
    assign ram_right = ram_rdata[2*ATTR_BITS-1:ATTR_BITS];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign table_empty = (used_reg == '0);
    assign issue       = (state_reg == ST_SCAN) && (issue_idx_reg < used_reg);
    assign match       = rd_valid_reg && (ram_left == left_reg);
    assign applies     = rd_valid_reg && ((ram_left & set_reg) == ram_left);
    assign grows       = applies && ((ram_right & set_reg) != ram_right);
    assign pass_end    = rd_valid_reg && rd_last_reg;

    always_comb
    begin
        if (kind_reg == KIND_INSERT)
        begin
            scan_done = match || pass_end || table_empty;
        end
        else
        begin
            scan_done = table_empty || (pass_end && !(changed_reg || grows));
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == KIND_INSERT || s_tuser == KIND_QUERY)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        kind_next      = kind_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        set_next       = set_reg;
        status_next    = status_reg;
        changed_next   = changed_reg;
        used_next      = used_reg;
        issue_idx_next = issue_idx_reg;
        rd_valid_next  = issue;
        rd_last_next   = issue && ((issue_idx_reg + CW'(1)) == used_reg);
        rd_addr_next   = issue_idx_reg[AW-1:0];
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_set_next     = m_set_reg;
        m_count_next   = m_count_reg;
        m_status_next  = m_status_reg;
        ram_we         = 1'b0;
        ram_waddr      = rd_addr_reg;
        ram_wdata      = {right_reg, left_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next      = s_tuser;
                    left_next      = s_tdata[ATTR_BITS-1:0];
                    right_next     = s_tdata[FIELD_W +: ATTR_BITS];
                    status_next    = STATUS_OK;
                    changed_next   = 1'b0;
                    issue_idx_next = '0;
                    set_next       = (s_tuser == KIND_QUERY) ? s_tdata[ATTR_BITS-1:0] : '0;
                    if (s_tuser == KIND_CLEAR)
                    begin
                        used_next = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    issue_idx_next = issue_idx_reg + CW'(1);
                end
                if (kind_reg == KIND_INSERT)
                begin
                    // the table is only written here, after the search has ended
                    priority if (match)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = rd_addr_reg;
                        ram_wdata = {ram_right | right_reg, left_reg};
                    end
                    else if (pass_end || table_empty)
                    begin
                        if (used_reg < DEPTH_C)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = used_reg[AW-1:0];
                            used_next = used_reg + CW'(1);
                        end
                        else
                        begin
                            status_next = STATUS_FULL;
                        end
                    end
                    else
                    begin
                        // still searching
                        ram_we = 1'b0;
                    end
                end
                else
                begin
                    if (applies)
                    begin
                        set_next = set_reg | ram_right;
                    end
                    // rule order matters only for speed; set grows one rule per cycle
                    if (pass_end && (changed_reg || grows))
                    begin
                        issue_idx_next = '0;
                        changed_next   = 1'b0;
                    end
                    else if (grows)
                    begin
                        changed_next = 1'b1;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_set_next    = set_reg;
                    m_count_next  = COUNT_W'(used_reg);
                    m_status_next = status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            changed_reg   <= 1'b0;
            issue_idx_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            rd_valid_reg  <= rd_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
            changed_reg   <= changed_next;
            issue_idx_reg <= issue_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        left_reg     <= left_next;
        right_reg    <= right_next;
        set_reg      <= set_next;
        status_reg   <= status_next;
        rd_last_reg  <= rd_last_next;
        rd_addr_reg  <= rd_addr_next;
        m_set_reg    <= m_set_next;
        m_count_reg  <= m_count_next;
        m_status_reg <= m_status_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_DATA_W - FIELD_W - COUNT_W){1'b0}}, m_count_reg,
                       FIELD_W'(m_set_reg)};
    assign m_tuser  = m_status_reg;

    `ACE_ASSERT_NOW(a_used_bound, clk, rst_n, 1'b1, used_reg <= DEPTH_C,
        "rule count beyond table depth")
    `ACE_ASSERT_NOW(a_write_in_scan, clk, rst_n, ram_we, state_reg == ST_SCAN,
        "rule table written outside a scan")
    `ACE_ASSERT_NOW(a_read_in_range, clk, rst_n, rd_valid_reg && state_reg == ST_SCAN,
        CW'(rd_addr_reg) < used_reg, "rule read beyond stored entries")
    `ACE_ASSERT_NEXT(a_full_keeps_count, clk, rst_n,
        state_reg == ST_SCAN && status_next == STATUS_FULL && status_reg == STATUS_OK,
        used_reg == DEPTH_C, "table full reported with room left")

endmodule
